@@ rtl/core/arf_pkg.sv @@
// Shared types and constants for the AT response receive FIFO.
package arf_pkg;

  localparam int BUF_DEPTH = 256;
  localparam int PTR_W     = $clog2(BUF_DEPTH);
  localparam int CNT_W     = (PTR_W + 1 > 8) ? PTR_W + 1 : 8;

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUF_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(BUF_DEPTH);

  // Request codes
  localparam logic [2:0] REQ_RX        = 3'd0;
  localparam logic [2:0] REQ_POP       = 3'd1;
  localparam logic [2:0] REQ_CLR_FLAGS = 3'd2;
  localparam logic [2:0] REQ_CLR_BUF   = 3'd3;
  localparam logic [2:0] REQ_FLUSH     = 3'd4;

  // Response result codes
  localparam logic [1:0] RES_NONE  = 2'd0;
  localparam logic [1:0] RES_OK    = 2'd1;
  localparam logic [1:0] RES_ERROR = 2'd2;

  // Characters watched by the terminator detector
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_O  = 8'h4F;
  localparam logic [7:0] CH_K  = 8'h4B;
  localparam logic [7:0] CH_E  = 8'h45;
  localparam logic [7:0] CH_R  = 8'h52;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] rx_byte;
  } req_word_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       read_valid;
    logic [7:0] fill_count;
    logic       resp_ready;
    logic [1:0] resp_result;
    logic       byte_dropped;
  } rsp_word_t;

  typedef struct packed {
    logic ok;
    logic err;
  } det_hit_t;

endpackage

@@ rtl/core/arf_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read.
module arf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/arf_detect.sv @@
// Terminator detector: tracks CR LF O K CR LF and E R R O R in the byte stream.
module arf_detect
  import arf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic       flush,
  input  logic [7:0] rx_byte,
  output det_hit_t   hit
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_CR1, ST_LF1, ST_O, ST_K, ST_CR2, ST_E, ST_R1, ST_R2, ST_O2
  } det_state_t;

  det_state_t state;
  det_state_t state_next;

  always_comb begin
    state_next = ST_IDLE;
    hit        = '0;
    unique case (state)
      ST_IDLE: begin
        if (rx_byte == CH_CR)      state_next = ST_CR1;
        else if (rx_byte == CH_E)  state_next = ST_E;
      end
      ST_CR1: if (rx_byte == CH_LF) state_next = ST_LF1;
      ST_LF1: begin
        if (rx_byte == CH_O)       state_next = ST_O;
        else if (rx_byte == CH_E)  state_next = ST_E;
        else if (rx_byte == CH_CR) state_next = ST_CR1;
      end
      ST_O:   if (rx_byte == CH_K)  state_next = ST_K;
      ST_K:   if (rx_byte == CH_CR) state_next = ST_CR2;
      ST_CR2: hit.ok = (rx_byte == CH_LF);
      ST_E:   if (rx_byte == CH_R)  state_next = ST_R1;
      ST_R1:  if (rx_byte == CH_R)  state_next = ST_R2;
      ST_R2:  if (rx_byte == CH_O)  state_next = ST_O2;
      ST_O2:  hit.err = (rx_byte == CH_R);
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else if (flush) begin
      state <= ST_IDLE;
    end else if (step) begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/core/at_response_rx_fifo.sv @@
// Receive byte FIFO with AT response terminator detection (top level).
// Response: a request word is answered in the cycle after it is accepted.
// Throughput: one word per cycle unless the response stalls; the store's
// single read port and single write port each see at most one access per word.
// Reset: synchronous; clears pointers, detector state, flags and valid bits;
// fill/drop and store contents stay undefined; only written entries are read.
module at_response_rx_fifo
  import arf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_word_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_word_t rsp
);

  // Pointer and flag state
  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] rp;
  logic [PTR_W-1:0] wp_next;
  logic [PTR_W-1:0] rp_next;
  logic [PTR_W-1:0] wp_inc;
  logic [PTR_W-1:0] rp_inc;
  logic             rdy_flag;
  logic             rdy_flag_next;
  logic [1:0]       res_code;
  logic [1:0]       res_code_next;

  // Output register; read data comes straight from the RAM's output register
  logic             pop_hit;
  logic [7:0]       fill_q;
  logic             drop_q;
  logic [7:0]       ram_rdata;

  logic             acc;
  logic             is_rx;
  logic             is_pop;
  logic             is_clr;
  logic             is_flush;
  logic             full;
  logic             empty;
  logic             wr_en;
  logic             rd_en;
  logic [CNT_W-1:0] wp_ext;
  logic [CNT_W-1:0] rp_ext;
  logic [CNT_W-1:0] fill_wide;
  det_hit_t         hit;

  // Advance whenever the output slot is free or being emptied this cycle
  assign req_ready = !rsp_valid || rsp_ready;
  assign acc       = req_valid && req_ready;

  assign is_rx    = (req.req_type == REQ_RX);
  assign is_pop   = (req.req_type == REQ_POP);
  assign is_flush = (req.req_type == REQ_FLUSH);
  assign is_clr   = (req.req_type == REQ_CLR_FLAGS) || (req.req_type == REQ_CLR_BUF) ||
                    is_flush;

  assign wp_inc = (wp == PTR_LAST) ? '0 : wp + 1'b1;
  assign rp_inc = (rp == PTR_LAST) ? '0 : rp + 1'b1;
  assign full   = (wp_inc == rp);
  assign empty  = (wp == rp);

  // Store the byte unless full; pop reads the head entry when not empty
  assign wr_en = acc && is_rx && !full;
  assign rd_en = acc && is_pop && !empty;

  arf_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wp),
    .wdata (req.rx_byte),
    .re    (rd_en),
    .raddr (rp),
    .rdata (ram_rdata)
  );

  arf_detect u_detect (
    .clk     (clk),
    .rst     (rst),
    .step    (acc && is_rx),
    .flush   (acc && is_flush),
    .rx_byte (req.rx_byte),
    .hit     (hit)
  );

  always_comb begin
    wp_next       = wp;
    rp_next       = rp;
    rdy_flag_next = rdy_flag;
    res_code_next = res_code;
    if (wr_en) wp_next = wp_inc;
    if (rd_en) rp_next = rp_inc;
    // Clear buffer and flush drop everything held
    if (req.req_type == REQ_CLR_BUF || is_flush) rp_next = wp;
    priority if (is_clr) begin
      rdy_flag_next = 1'b0;
      res_code_next = RES_NONE;
    end else if (is_rx && hit.ok) begin
      rdy_flag_next = 1'b1;
      res_code_next = RES_OK;
    end else if (is_rx && hit.err) begin
      rdy_flag_next = 1'b1;
      res_code_next = RES_ERROR;
    end else begin
      rdy_flag_next = rdy_flag;
      res_code_next = res_code;
    end
  end

  assign wp_ext    = CNT_W'(wp_next);
  assign rp_ext    = CNT_W'(rp_next);
  assign fill_wide = (wp_ext >= rp_ext) ? wp_ext - rp_ext : wp_ext + CNT_DEPTH - rp_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp        <= '0;
      rp        <= '0;
      rdy_flag  <= 1'b0;
      res_code  <= RES_NONE;
      rsp_valid <= 1'b0;
      pop_hit   <= 1'b0;
    end else begin
      if (acc) begin
        wp       <= wp_next;
        rp       <= rp_next;
        rdy_flag <= rdy_flag_next;
        res_code <= res_code_next;
        pop_hit  <= rd_en;
      end
      if (acc) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Status fields need no reset; they only matter under rsp_valid
  always_ff @(posedge clk) begin
    if (acc) begin
      fill_q <= fill_wide[7:0];
      drop_q <= is_rx && full;
    end
  end

  // Flags are sampled from the state registers, which hold until the next word
  always_comb begin
    rsp.read_byte    = pop_hit ? ram_rdata : 8'h00;
    rsp.read_valid   = pop_hit;
    rsp.fill_count   = fill_q;
    rsp.resp_ready   = rdy_flag;
    rsp.resp_result  = res_code;
    rsp.byte_dropped = drop_q;
  end

  // A pop on a non-empty FIFO must come back with stored data
  assert property (@(posedge clk) disable iff (rst)
    (acc && is_pop && !empty) |=> (rsp_valid && rsp.read_valid))
    else $error("pop on non-empty FIFO returned no data");

  // A receive into a full FIFO is flagged and leaves the count unchanged
  assert property (@(posedge clk) disable iff (rst)
    (acc && is_rx && full) |=> (rsp.byte_dropped && $stable(wp)))
    else $error("byte into full FIFO not dropped");

  // A flush leaves an empty FIFO and no pending response
  assert property (@(posedge clk) disable iff (rst)
    (acc && is_flush) |=> (rsp.fill_count == 8'h00 && !rsp.resp_ready &&
                           rsp.resp_result == RES_NONE))
    else $error("flush left state behind");

  // Read data is only presented for a pop that hit stored data
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.read_valid) |-> (rsp.read_byte == 8'h00))
    else $error("read byte nonzero without valid pop");

endmodule
